FILE: rtl/core/pil_pkg.sv
// Package for the priority inheritance lock core.
// Holds the result and request codes, the controller state type, and the
// command and status structs. It has no dependencies.
`timescale 1ns / 1ps

package pil_pkg;

  localparam int unsigned TidW  = 4;
  localparam int unsigned PrioW = 8;
  localparam int unsigned KindW = 3;

  // Number of task identifiers; a request's identifier is reduced modulo this value.
  localparam int unsigned TaskCount = 16;

  localparam logic MODE_LOCK   = 1'b0;
  localparam logic MODE_UNLOCK = 1'b1;

  typedef enum logic [KindW-1:0] {
    KIND_GRANTED  = 3'd0,
    KIND_QUEUED   = 3'd1,
    KIND_ALREADY  = 3'd2,
    KIND_FULL     = 3'd3,
    KIND_RELEASED = 3'd4,
    KIND_IGNORED  = 3'd5,
    KIND_WAKE     = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WAKE
  } ctrl_state_e;

  typedef struct packed {
    logic load_req;
    logic exec;
    logic wake;
  } pil_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic release_wake;
    logic wake_last;
  } pil_sts_t;

  function automatic logic [TidW-1:0] reduce_tid(input logic [TidW-1:0] id);
    logic [8:0] v;
    v = {5'b0, id};
    for (int k = 0; k < 8; k++) begin
      if (v >= 9'(TaskCount)) begin
        v = v - 9'(TaskCount);
      end
    end
    return v[TidW-1:0];
  endfunction

endpackage

FILE: rtl/core/pil_if.sv
// Valid/ready channel interfaces for requests and results of the lock core.
// Depends on nothing; field widths match pil_pkg.
`timescale 1ns / 1ps

interface pil_req_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [3:0] task_id;
  logic [7:0] task_priority;
  logic [7:0] orig_priority;

  modport source (output valid, mode, task_id, task_priority, orig_priority, input ready);
  modport sink (input valid, mode, task_id, task_priority, orig_priority, output ready);
endinterface

interface pil_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [3:0] subject_task;
  logic [3:0] owner_task;
  logic       set_priority;
  logic [7:0] new_priority;
  logic       last;

  modport source (output valid, kind, subject_task, owner_task, set_priority, new_priority,
                  last, input ready);
  modport sink (input valid, kind, subject_task, owner_task, set_priority, new_priority,
                last, output ready);
endinterface

FILE: rtl/core/pil_ctrl.sv
// Controller state machine of the lock core.
// Sequences request capture, execution and the wake results; uses pil_pkg.
`timescale 1ns / 1ps

module pil_ctrl import pil_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  output logic     req_ready_o,
  input  pil_sts_t sts_i,
  output pil_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o    = 1'b1;
        cmd_o.load_req = req_valid_i;
        if (req_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.slot_free) begin
          cmd_o.exec = 1'b1;
          state_d    = sts_i.release_wake ? ST_WAKE : ST_IDLE;
        end
      end
      ST_WAKE: begin
        if (sts_i.slot_free) begin
          cmd_o.wake = 1'b1;
          if (sts_i.wake_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/pil_datapath.sv
// Datapath of the lock core: request register, lock state, waiter list and
// result register. Uses pil_pkg and the result channel interface.
`timescale 1ns / 1ps

module pil_datapath import pil_pkg::*; #(
  parameter int unsigned MAX_WAITERS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               mode_i,
  input  logic [TidW-1:0]    task_id_i,
  input  logic [PrioW-1:0]   task_priority_i,
  input  logic [PrioW-1:0]   orig_priority_i,
  input  pil_cmd_t           cmd_i,
  output pil_sts_t           sts_o,
  pil_rsp_if.source          rsp_o
);

  localparam int unsigned CntW = $clog2(MAX_WAITERS + 1);
  localparam int unsigned IdxW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;

  logic             mode_q;
  logic [TidW-1:0]  tid_q;
  logic [PrioW-1:0] prio_q;
  logic [PrioW-1:0] base_q;

  logic             held_q, held_d;
  logic [TidW-1:0]  holder_q, holder_d;
  logic [PrioW-1:0] hprio_q, hprio_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [IdxW-1:0]  wake_idx_q, wake_idx_d;
  logic [(2**TidW)-1:0] present_q, present_d;
  logic [TidW-1:0]  ids_q [MAX_WAITERS];

  logic             out_valid_q;
  kind_e            kind_q, kind_d;
  logic [TidW-1:0]  subj_q, subj_d;
  logic [TidW-1:0]  owner_q, owner_d;
  logic             setp_q, setp_d;
  logic [PrioW-1:0] newp_q, newp_d;
  logic             last_q, last_d;

  logic             list_write;
  logic             boost;
  logic             is_holder;
  logic             wake_last;

  assign boost     = prio_q > hprio_q;
  assign is_holder = held_q && (holder_q == tid_q);
  assign wake_last = (CntW'(wake_idx_q) + CntW'(1)) == count_q;

  assign sts_o.slot_free    = !out_valid_q || rsp_o.ready;
  assign sts_o.release_wake = (mode_q == MODE_UNLOCK) && is_holder && (count_q != '0);
  assign sts_o.wake_last    = wake_last;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      mode_q <= mode_i;
      tid_q  <= reduce_tid(task_id_i);
      prio_q <= task_priority_i;
      base_q <= orig_priority_i;
    end
    if (list_write) begin
      ids_q[count_q[IdxW-1:0]] <= tid_q;
    end
    if (cmd_i.exec || cmd_i.wake) begin
      kind_q  <= kind_d;
      subj_q  <= subj_d;
      owner_q <= owner_d;
      setp_q  <= setp_d;
      newp_q  <= newp_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= 1'b0;
      holder_q    <= '0;
      hprio_q     <= '0;
      count_q     <= '0;
      wake_idx_q  <= '0;
      present_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      held_q     <= held_d;
      holder_q   <= holder_d;
      hprio_q    <= hprio_d;
      count_q    <= count_d;
      wake_idx_q <= wake_idx_d;
      present_q  <= present_d;
      if (cmd_i.exec || cmd_i.wake) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    held_d     = held_q;
    holder_d   = holder_q;
    hprio_d    = hprio_q;
    count_d    = count_q;
    wake_idx_d = wake_idx_q;
    present_d  = present_q;
    list_write = 1'b0;
    kind_d     = KIND_IGNORED;
    subj_d     = tid_q;
    owner_d    = holder_q;
    setp_d     = 1'b0;
    newp_d     = '0;
    last_d     = 1'b1;

    if (cmd_i.exec) begin
      if (mode_q == MODE_LOCK) begin
        if (!held_q) begin
          held_d   = 1'b1;
          holder_d = tid_q;
          hprio_d  = prio_q;
          kind_d   = KIND_GRANTED;
          owner_d  = tid_q;
        end else begin
          if (boost) begin
            hprio_d = prio_q;
            setp_d  = 1'b1;
            newp_d  = prio_q;
          end
          if (present_q[tid_q]) begin
            kind_d = KIND_ALREADY;
          end else if (count_q < CntW'(MAX_WAITERS)) begin
            list_write       = 1'b1;
            count_d          = count_q + CntW'(1);
            present_d[tid_q] = 1'b1;
            kind_d           = KIND_QUEUED;
          end else begin
            kind_d = KIND_FULL;
          end
        end
      end else if (is_holder) begin
        held_d     = 1'b0;
        holder_d   = '0;
        hprio_d    = '0;
        wake_idx_d = '0;
        kind_d     = KIND_RELEASED;
        owner_d    = tid_q;
        setp_d     = 1'b1;
        newp_d     = base_q;
        last_d     = (count_q == '0);
      end
    end else if (cmd_i.wake) begin
      kind_d  = KIND_WAKE;
      subj_d  = ids_q[wake_idx_q];
      owner_d = '0;
      last_d  = wake_last;
      if (wake_last) begin
        count_d    = '0;
        present_d  = '0;
        wake_idx_d = '0;
      end else begin
        wake_idx_d = wake_idx_q + IdxW'(1);
      end
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.kind         = kind_q;
  assign rsp_o.subject_task = subj_q;
  assign rsp_o.owner_task   = owner_q;
  assign rsp_o.set_priority = setp_q;
  assign rsp_o.new_priority = newp_q;
  assign rsp_o.last         = last_q;

endmodule

FILE: rtl/core/priority_inheritance_lock_core.sv
// Priority inheritance lock: a request is captured in the request register while
// the controller is idle; its result is then written to the shared output register
// in the execute state; a release with waiters adds one wake result per waiter.
// A stalled result port holds the sequencer until its slot frees.
// Reset frees the lock, clears the holder, its priority and the waiter list.
`timescale 1ns / 1ps

module priority_inheritance_lock_core import pil_pkg::*; #(
  parameter int unsigned MAX_WAITERS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pil_req_if.sink   req_i,
  pil_rsp_if.source rsp_o
);

  pil_cmd_t cmd;
  pil_sts_t sts;

  pil_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pil_datapath #(
    .MAX_WAITERS (MAX_WAITERS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .mode_i          (req_i.mode),
    .task_id_i       (req_i.task_id),
    .task_priority_i (req_i.task_priority),
    .orig_priority_i (req_i.orig_priority),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .rsp_o           (rsp_o)
  );

endmodule

FILE: verif/tb_top.sv
// Testbench for priority_inheritance_lock_core: directed lock/unlock table, then random
// lock episodes and noise, checked against an in-bench model of the mutex and waiter list.
// Depends on pil_pkg, pil_req_if and pil_rsp_if from the RTL.
`timescale 1ns / 1ps

module tb_top;
  import pil_pkg::*;

  localparam int unsigned MaxWaiters = 8;
  localparam int unsigned DirectedExtra = 225;
  localparam int unsigned HoldCycles = 150;
  localparam int unsigned QuietLimit = 1000;
  localparam int unsigned TailCycles = 20;

  typedef struct packed {
    logic       mode;
    logic [3:0] task_id;
    logic [7:0] task_priority;
    logic [7:0] orig_priority;
  } lock_req_t;

  typedef struct packed {
    kind_e      kind;
    logic [3:0] subject;
    logic [3:0] owner;
    logic       set_prio;
    logic [7:0] new_prio;
    logic       last;
  } lock_outcome_t;

  typedef struct packed {
    lock_req_t     req;
    logic          typed;
    lock_outcome_t want;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pil_req_if req_ch ();
  pil_rsp_if rsp_ch ();

  priority_inheritance_lock_core #(
    .MAX_WAITERS(MaxWaiters)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .rsp_o (rsp_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Model of the mutex.
  logic          mx_held;
  logic [3:0]    mx_owner;
  logic [7:0]    mx_owner_prio;
  int unsigned   mx_waiters;
  logic [3:0]    waiter_ids[MaxWaiters];
  lock_outcome_t expected_outcomes[$];

  // Side information that travels with the request being offered.
  logic          drv_typed;
  lock_outcome_t drv_want;

  logic          calm;
  logic          hold_pending;
  plan_row_t     plan[$];

  int unsigned requests_sent;
  int unsigned results_checked;
  int unsigned mismatch_count;
  int unsigned fail_count;
  int unsigned wake_count;
  int unsigned full_count;
  int unsigned boost_count;

  task automatic predict_lock_outcome(input lock_req_t r);
    logic [3:0]    tid;
    logic          dup;
    lock_outcome_t o;
    tid = 4'(r.task_id % TaskCount);
    o = lock_outcome_t'(0);
    o.subject = tid;
    o.last = 1'b1;
    if (r.mode == MODE_LOCK) begin
      if (!mx_held) begin
        mx_held = 1'b1;
        mx_owner = tid;
        mx_owner_prio = r.task_priority;
        o.kind = KIND_GRANTED;
        o.owner = tid;
      end else begin
        if (r.task_priority > mx_owner_prio) begin
          mx_owner_prio = r.task_priority;
          o.set_prio = 1'b1;
          o.new_prio = r.task_priority;
        end
        dup = 1'b0;
        for (int unsigned i = 0; i < mx_waiters; i++) begin
          if (waiter_ids[i] == tid) begin
            dup = 1'b1;
          end
        end
        if (dup) begin
          o.kind = KIND_ALREADY;
        end else if (mx_waiters < MaxWaiters) begin
          waiter_ids[mx_waiters] = tid;
          mx_waiters++;
          o.kind = KIND_QUEUED;
        end else begin
          o.kind = KIND_FULL;
        end
        o.owner = mx_owner;
      end
      expected_outcomes.push_back(o);
    end else if (!mx_held || mx_owner != tid) begin
      o.kind = KIND_IGNORED;
      o.owner = mx_held ? mx_owner : 4'd0;
      expected_outcomes.push_back(o);
    end else begin
      mx_held = 1'b0;
      mx_owner = 4'd0;
      mx_owner_prio = 8'd0;
      o.kind = KIND_RELEASED;
      o.owner = tid;
      o.set_prio = 1'b1;
      o.new_prio = r.orig_priority;
      o.last = (mx_waiters == 0);
      expected_outcomes.push_back(o);
      for (int unsigned i = 0; i < mx_waiters; i++) begin
        o = lock_outcome_t'(0);
        o.kind = KIND_WAKE;
        o.subject = waiter_ids[i];
        o.last = (i + 1 == mx_waiters);
        expected_outcomes.push_back(o);
      end
      mx_waiters = 0;
    end
  endtask

  // Transfers are observed at the rising edge; results are checked before the
  // request of the same edge is predicted.
  always @(posedge clk_i) begin : observe
    lock_outcome_t got;
    lock_outcome_t want;
    lock_req_t     r;
    if (rst_ni) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.kind = kind_e'(rsp_ch.kind);
        got.subject = rsp_ch.subject_task;
        got.owner = rsp_ch.owner_task;
        got.set_prio = rsp_ch.set_priority;
        got.new_prio = rsp_ch.new_priority;
        got.last = rsp_ch.last;
        results_checked++;
        if (got.kind == KIND_WAKE) wake_count++;
        if (got.kind == KIND_FULL) full_count++;
        if (got.set_prio && got.kind != KIND_RELEASED) boost_count++;
        if (expected_outcomes.size() == 0) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("tb_top: unexpected result kind %0d subject %0d", got.kind, got.subject);
          end
        end else begin
          want = expected_outcomes.pop_front();
          if (got.kind !== want.kind || got.subject !== want.subject ||
              got.owner !== want.owner || got.set_prio !== want.set_prio ||
              got.new_prio !== want.new_prio || got.last !== want.last) begin
            fail_count++;
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("tb_top: mismatch at result %0d: expected kind %0d subj %0d own %0d",
                       results_checked, want.kind, want.subject, want.owner);
              $display("tb_top:   expected set %0b prio %0d last %0b",
                       want.set_prio, want.new_prio, want.last);
              $display("tb_top:   actual kind %0d subj %0d own %0d set %0b prio %0d last %0b",
                       got.kind, got.subject, got.owner, got.set_prio, got.new_prio, got.last);
            end
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        r.mode = req_ch.mode;
        r.task_id = req_ch.task_id;
        r.task_priority = req_ch.task_priority;
        r.orig_priority = req_ch.orig_priority;
        predict_lock_outcome(r);
        if (drv_typed) begin
          void'(expected_outcomes.pop_back());
          expected_outcomes.push_back(drv_want);
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic offer(input logic m, input logic [3:0] t, input logic [7:0] p,
                       input logic [7:0] b, input logic typed, input lock_outcome_t want);
    if (!calm && $urandom_range(0, 4) == 0) begin
      req_ch.valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    req_ch.valid = 1'b1;
    req_ch.mode = m;
    req_ch.task_id = t;
    req_ch.task_priority = p;
    req_ch.orig_priority = b;
    drv_typed = typed;
    drv_want = want;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    requests_sent++;
    @(negedge clk_i);
  endtask

  task automatic add_row(input logic m, input logic [3:0] t, input logic [7:0] p,
                         input logic [7:0] b, input logic typed, input kind_e k,
                         input logic [3:0] s, input logic [3:0] o, input logic sp,
                         input logic [7:0] np, input logic l);
    plan_row_t row;
    row.req = '{mode: m, task_id: t, task_priority: p, orig_priority: b};
    row.typed = typed;
    row.want = '{kind: k, subject: s, owner: o, set_prio: sp, new_prio: np, last: l};
    plan.push_back(row);
  endtask

  // A well-formed episode: free the lock if needed, grant it, pile up waiters
  // (with duplicates, stray unlocks and overflow), then release it.
  task automatic lock_episode();
    logic [3:0] owner;
    logic [3:0] t;
    logic [3:0] prev;
    int unsigned n;
    if (mx_held) begin
      offer(MODE_UNLOCK, mx_owner, 8'($urandom), 8'($urandom), 1'b0, lock_outcome_t'(0));
    end
    owner = 4'($urandom);
    prev = owner;
    offer(MODE_LOCK, owner, 8'($urandom_range(0, 255)), 8'($urandom), 1'b0, lock_outcome_t'(0));
    n = $urandom_range(0, 11);
    repeat (n) begin
      if ($urandom_range(0, 7) == 0) begin
        offer(MODE_UNLOCK, 4'($urandom), 8'($urandom), 8'($urandom), 1'b0, lock_outcome_t'(0));
      end else begin
        t = ($urandom_range(0, 4) == 0) ? prev : 4'($urandom);
        prev = t;
        offer(MODE_LOCK, t, 8'($urandom), 8'($urandom), 1'b0, lock_outcome_t'(0));
      end
    end
    offer(MODE_UNLOCK, owner, 8'($urandom), 8'($urandom), 1'b0, lock_outcome_t'(0));
  endtask

  initial begin : receiver
    rsp_ch.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        rsp_ch.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready = 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
      end
      rsp_ch.ready = 1'b1;
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    wait (rst_ni);
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb_top: no transfer for %0d cycles", QuietLimit);
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin : stimulus
    int unsigned goal;
    logic        hold_done;
    logic        drain_done;
    rst_ni = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.mode = MODE_LOCK;
    req_ch.task_id = 4'd0;
    req_ch.task_priority = 8'd0;
    req_ch.orig_priority = 8'd0;
    drv_typed = 1'b0;
    drv_want = lock_outcome_t'(0);
    calm = 1'b0;
    hold_pending = 1'b0;
    hold_done = 1'b0;
    drain_done = 1'b0;
    mx_held = 1'b0;
    mx_owner = 4'd0;
    mx_owner_prio = 8'd0;
    mx_waiters = 0;
    foreach (waiter_ids[i]) waiter_ids[i] = 4'd0;
    requests_sent = 0;
    results_checked = 0;
    mismatch_count = 0;
    fail_count = 0;
    wake_count = 0;
    full_count = 0;
    boost_count = 0;

    add_row(MODE_UNLOCK, 4'd3, 8'd0, 8'd0, 1'b1, KIND_IGNORED, 4'd3, 4'd0, 1'b0, 8'd0, 1'b1);
    add_row(MODE_LOCK, 4'd10, 8'd0, 8'd0, 1'b1, KIND_GRANTED, 4'd10, 4'd10, 1'b0, 8'd0, 1'b1);
    add_row(MODE_LOCK, 4'd15, 8'd200, 8'd0, 1'b1, KIND_QUEUED, 4'd15, 4'd10, 1'b1, 8'd200, 1'b1);
    add_row(MODE_LOCK, 4'd15, 8'd201, 8'd255, 1'b1, KIND_ALREADY, 4'd15, 4'd10, 1'b1, 8'd201,
            1'b1);
    add_row(MODE_LOCK, 4'd10, 8'd5, 8'd0, 1'b1, KIND_QUEUED, 4'd10, 4'd10, 1'b0, 8'd0, 1'b1);
    for (int i = 1; i <= 6; i++) begin
      add_row(MODE_LOCK, 4'(i), 8'd1, 8'd0, 1'b0, KIND_GRANTED, 4'd0, 4'd0, 1'b0, 8'd0, 1'b0);
    end
    add_row(MODE_LOCK, 4'd7, 8'd255, 8'd0, 1'b1, KIND_FULL, 4'd7, 4'd10, 1'b1, 8'd255, 1'b1);
    add_row(MODE_LOCK, 4'd8, 8'd255, 8'd0, 1'b1, KIND_FULL, 4'd8, 4'd10, 1'b0, 8'd0, 1'b1);
    add_row(MODE_UNLOCK, 4'd9, 8'd0, 8'd0, 1'b1, KIND_IGNORED, 4'd9, 4'd10, 1'b0, 8'd0, 1'b1);
    add_row(MODE_UNLOCK, 4'd10, 8'd0, 8'd255, 1'b0, KIND_GRANTED, 4'd0, 4'd0, 1'b0, 8'd0,
            1'b0);
    add_row(MODE_LOCK, 4'd0, 8'd255, 8'd255, 1'b1, KIND_GRANTED, 4'd0, 4'd0, 1'b0, 8'd0, 1'b1);
    add_row(MODE_UNLOCK, 4'd0, 8'd255, 8'd0, 1'b1, KIND_RELEASED, 4'd0, 4'd0, 1'b1, 8'd0, 1'b1);
    add_row(MODE_LOCK, 4'd15, 8'd255, 8'd255, 1'b1, KIND_GRANTED, 4'd15, 4'd15, 1'b0, 8'd0,
            1'b1);
    add_row(MODE_LOCK, 4'd3, 8'd0, 8'd0, 1'b0, KIND_GRANTED, 4'd0, 4'd0, 1'b0, 8'd0, 1'b0);
    add_row(MODE_LOCK, 4'd3, 8'd0, 8'd0, 1'b1, KIND_ALREADY, 4'd3, 4'd15, 1'b0, 8'd0, 1'b1);
    add_row(MODE_UNLOCK, 4'd15, 8'd0, 8'd128, 1'b0, KIND_GRANTED, 4'd0, 4'd0, 1'b0, 8'd0,
            1'b0);
    add_row(MODE_UNLOCK, 4'd15, 8'd0, 8'd0, 1'b1, KIND_IGNORED, 4'd15, 4'd0, 1'b0, 8'd0, 1'b1);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[k]) begin
      offer(plan[k].req.mode, plan[k].req.task_id, plan[k].req.task_priority,
            plan[k].req.orig_priority, plan[k].typed, plan[k].want);
    end

    goal = requests_sent + DirectedExtra;
    while (requests_sent < goal) begin
      if (!hold_done && requests_sent >= goal - 160) begin
        hold_done = 1'b1;
        hold_pending = 1'b1;
      end
      if (!drain_done && requests_sent >= goal - 90) begin
        drain_done = 1'b1;
        req_ch.valid = 1'b0;
        while (expected_outcomes.size() != 0) @(negedge clk_i);
        @(negedge clk_i);
      end
      if (requests_sent >= goal - 45) calm = 1'b1;
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          offer(1'($urandom), 4'($urandom), 8'($urandom), 8'($urandom), 1'b0,
                lock_outcome_t'(0));
        end
      end else begin
        lock_episode();
      end
    end
    req_ch.valid = 1'b0;

    while (expected_outcomes.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (expected_outcomes.size() != 0) fail_count++;

    $display("tb_top: %0d requests sent, %0d results checked, %0d mismatches",
             requests_sent, results_checked, mismatch_count);
    $display("tb_top: %0d wakes, %0d full-list reports, %0d priority boosts seen",
             wake_count, full_count, boost_count);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
